[hdl/cmwe_pkg.sv]
`timescale 1ns / 1ps
// cmwe_pkg: shared types and codes of the column melt wipe engine
// item and result payloads, decoded command format, action and register codes
package cmwe_pkg;

	localparam logic [1:0] ACT_SEED  = 2'd0;
	localparam logic [1:0] ACT_TICK  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;
	localparam logic [1:0] ACT_NOP   = 2'd3;

	localparam logic [1:0] CFG_COLUMNS_IN_USE  = 2'd0;
	localparam logic [1:0] CFG_SCREEN_ROWS     = 2'd1;
	localparam logic [1:0] CFG_FIXED_STEP_MODE = 2'd2;

	localparam logic [9:0] COLUMNS_RESET = 10'd160;
	localparam logic [9:0] ROWS_RESET    = 10'd200;

	typedef struct packed {
		logic [1:0] action;
		logic [8:0] column;
		logic [9:0] row;
		logic [3:0] random_value;
		logic [4:0] tick_count;
	} item_t;

	typedef struct packed {
		logic       done_res;
		logic       from_end_screen;
		logic [9:0] source_row;
	} res_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_SEED_FIRST,
		CMD_SEED_NEXT,
		CMD_TICK,
		CMD_QUERY_RD,
		CMD_QUERY_ZERO
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [8:0] column;
		logic [9:0] row;
		logic [3:0] random_value;
		logic [1:0] random_mod3;
		logic [4:0] tick_count;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t head;
	} cmd_head_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_SEED,
		BK_QUERY,
		BK_TICK
	} back_state_t;

endpackage

[hdl/cmwe_ram.sv]
`timescale 1ns / 1ps
// cmwe_ram: generic single write port, single read port ram
// registered read data, read of a location being written returns old data
module cmwe_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

[hdl/cmwe_queue.sv]
`timescale 1ns / 1ps
// cmwe_queue: two-entry command queue between front and back
// depends on cmwe_pkg for the command type
module cmwe_queue import cmwe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	output logic      full,
	input  logic      pop,
	output cmd_head_t head
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

[hdl/cmwe_front.sv]
`timescale 1ns / 1ps
// cmwe_front: accepts input transactions and classifies them into commands
// depends on cmwe_pkg for item and command types
module cmwe_front import cmwe_pkg::*; #(
	parameter int MAX_COLUMNS = 512
) (
	input  logic  item_valid,
	input  item_t item_data,
	output logic  item_stall,
	input  logic  queue_full,
	output logic  push,
	output cmd_t  push_cmd
);

	function automatic logic [1:0] mod3(input logic [3:0] v);
		logic [1:0] r;
		case (v)
			4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: r = 2'd0;
			4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       r = 2'd1;
			default:                              r = 2'd2;
		endcase
		return r;
	endfunction

	logic in_range;

	assign item_stall = queue_full;
	assign push       = item_valid && !queue_full;
	assign in_range   = (32'(item_data.column) < MAX_COLUMNS);

	always_comb begin
		push_cmd.column       = item_data.column;
		push_cmd.row          = item_data.row;
		push_cmd.random_value = item_data.random_value;
		push_cmd.random_mod3  = mod3(item_data.random_value);
		push_cmd.tick_count   = item_data.tick_count;
		push_cmd.op           = CMD_NONE;
		unique case (item_data.action)
			ACT_SEED: begin
				if (!in_range) begin
					push_cmd.op = CMD_NONE;
				end else if (item_data.column == 9'd0) begin
					push_cmd.op = CMD_SEED_FIRST;
				end else begin
					push_cmd.op = CMD_SEED_NEXT;
				end
			end
			ACT_TICK: begin
				push_cmd.op = CMD_TICK;
			end
			ACT_QUERY: begin
				push_cmd.op = in_range ? CMD_QUERY_RD : CMD_QUERY_ZERO;
			end
			ACT_NOP: begin
				push_cmd.op = CMD_NONE;
			end
		endcase
	end

endmodule

[hdl/cmwe_back.sv]
`timescale 1ns / 1ps
// cmwe_back: executes seed, tick and query commands against the offset ram
// depends on cmwe_pkg and cmwe_ram; owns the result register
module cmwe_back import cmwe_pkg::*; #(
	parameter int MAX_COLUMNS = 512,
	parameter int ROW_BITS    = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_head_t head,
	output logic      pop,
	input  logic [9:0] columns_in_use,
	input  logic [9:0] screen_rows,
	input  logic      fixed_step_mode,
	output logic      res_valid,
	output res_t      res_data,
	input  logic      res_stall
);

	localparam int OW = ROW_BITS + 2;
	localparam int AW = $clog2(MAX_COLUMNS);
	localparam int CW = ((OW > 11) ? OW : 11) + 2;

	localparam logic signed [CW-1:0] OMAX = CW'((1 << (OW - 1)) - 1);
	localparam logic signed [CW-1:0] OMIN = CW'(-(1 << (OW - 1)));
	localparam logic signed [CW-1:0] ZERO = CW'(0);
	localparam logic signed [CW-1:0] ONE  = CW'(1);
	localparam logic signed [CW-1:0] C8   = CW'(8);
	localparam logic signed [CW-1:0] C13  = CW'(13);
	localparam logic signed [CW-1:0] C16  = CW'(16);
	localparam logic signed [CW-1:0] CM15 = CW'(-15);
	localparam logic signed [CW-1:0] CM16 = CW'(-16);

	function automatic logic signed [OW-1:0] sat(input logic signed [CW-1:0] v);
		logic signed [OW-1:0] r;
		if (v > OMAX) begin
			r = OMAX[OW-1:0];
		end else if (v < OMIN) begin
			r = OMIN[OW-1:0];
		end else begin
			r = v[OW-1:0];
		end
		return r;
	endfunction

	function automatic logic signed [OW-1:0] seed_next(input logic signed [OW-1:0] prev,
			input logic [1:0] m);
		logic signed [CW-1:0] v;
		v = CW'(prev) + signed'(CW'(m)) - ONE;
		if (v > ZERO) begin
			v = ZERO;
		end else if (v == CM16) begin
			v = CM15;
		end
		return sat(v);
	endfunction

	function automatic logic signed [OW-1:0] melt(input logic signed [OW-1:0] y,
			input logic [9:0] h, input logic fixed);
		logic signed [CW-1:0] ye;
		logic signed [CW-1:0] he;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] nv;
		ye = CW'(y);
		he = signed'(CW'(h));
		dy = (ye < C16) ? ye + ONE : C8;
		if (ye < ZERO) begin
			nv = ye + ONE;
		end else if (ye < he) begin
			if (fixed) begin
				nv = ye + C13;
			end else if (ye + dy >= he) begin
				nv = he;
			end else begin
				nv = ye + dy;
			end
		end else begin
			nv = ye;
		end
		return sat(nv);
	endfunction

	function automatic res_t query(input logic [9:0] row, input logic signed [OW-1:0] y,
			input logic fixed);
		res_t                 r;
		logic signed [CW-1:0] ye;
		logic signed [CW-1:0] re;
		logic signed [CW-1:0] diff;
		ye   = (y < 0) ? ZERO : CW'(y);
		re   = signed'(CW'(row));
		diff = re - ye;
		r.done_res        = 1'b0;
		r.from_end_screen = 1'b0;
		r.source_row      = row;
		if (!fixed) begin
			if (re < ye) begin
				r.from_end_screen = 1'b1;
			end else begin
				r.source_row = diff[9:0];
			end
		end
		return r;
	endfunction

	back_state_t state_q;
	back_state_t state_d;
	cmd_t        cmd_q;

	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic [OW-1:0]        rd_data;
	logic                 wr_en;
	logic [AW-1:0]        wr_addr;
	logic signed [OW-1:0] wr_data;

	logic                 fwd_s1;
	logic signed [OW-1:0] fwd_data_s1;
	logic signed [OW-1:0] y_s1;

	logic                 pend_s1;
	logic [AW-1:0]        addr_s1;
	logic [AW-1:0]        ri_q;
	logic [AW-1:0]        last_q;
	logic [AW-1:0]        last_d;
	logic [4:0]           pass_q;
	logic                 issuing_q;
	logic                 moved_q;
	logic                 start_tick;
	logic                 step_moved;

	logic res_load;
	res_t res_next;
	logic res_valid_q;
	res_t res_q;

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	assign y_s1 = fwd_s1 ? fwd_data_s1 : signed'(rd_data);
	assign step_moved = (y_s1 < 0) || (signed'(CW'(y_s1)) < signed'(CW'(screen_rows)));

	always_comb begin
		if (32'(columns_in_use) >= MAX_COLUMNS) begin
			last_d = AW'(MAX_COLUMNS - 1);
		end else begin
			last_d = AW'(columns_in_use - 10'd1);
		end
	end

	cmwe_ram #(
		.WIDTH (OW),
		.DEPTH (MAX_COLUMNS)
	) u_ofs_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		state_d    = state_q;
		pop        = 1'b0;
		res_load   = 1'b0;
		res_next   = '0;
		rd_en      = 1'b0;
		rd_addr    = ri_q;
		wr_en      = 1'b0;
		wr_addr    = addr_s1;
		wr_data    = melt(y_s1, screen_rows, fixed_step_mode);
		start_tick = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (head.valid && (!res_valid_q || !res_stall)) begin
					pop = 1'b1;
					case (head.head.op)
						CMD_SEED_FIRST: begin
							wr_en    = 1'b1;
							wr_addr  = AW'(head.head.column);
							wr_data  = sat(ZERO - signed'(CW'(head.head.random_value)));
							res_load = 1'b1;
						end
						CMD_SEED_NEXT: begin
							rd_en   = 1'b1;
							rd_addr = AW'(head.head.column - 9'd1);
							state_d = BK_SEED;
						end
						CMD_QUERY_RD: begin
							rd_en   = 1'b1;
							rd_addr = AW'(head.head.column);
							state_d = BK_QUERY;
						end
						CMD_QUERY_ZERO: begin
							res_load = 1'b1;
							res_next = query(head.head.row, '0, fixed_step_mode);
						end
						CMD_TICK: begin
							if (head.head.tick_count == 5'd0 || columns_in_use == 10'd0) begin
								res_load          = 1'b1;
								res_next.done_res = 1'b1;
							end else begin
								start_tick = 1'b1;
								state_d    = BK_TICK;
							end
						end
						default: begin
							res_load = 1'b1;
						end
					endcase
				end
			end
			BK_SEED: begin
				wr_en    = 1'b1;
				wr_addr  = AW'(cmd_q.column);
				wr_data  = seed_next(y_s1, cmd_q.random_mod3);
				res_load = 1'b1;
				state_d  = BK_IDLE;
			end
			BK_QUERY: begin
				res_load = 1'b1;
				res_next = query(cmd_q.row, y_s1, fixed_step_mode);
				state_d  = BK_IDLE;
			end
			BK_TICK: begin
				rd_en = issuing_q;
				wr_en = pend_s1;
				if (!issuing_q && !pend_s1) begin
					res_load          = 1'b1;
					res_next.done_res = !moved_q;
					state_d           = BK_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		fwd_data_s1 <= wr_data;
		addr_s1     <= ri_q;
		if (pop) begin
			cmd_q <= head.head;
		end
		if (res_load) begin
			res_q <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			res_valid_q <= 1'b0;
			fwd_s1      <= 1'b0;
			pend_s1     <= 1'b0;
			issuing_q   <= 1'b0;
			moved_q     <= 1'b0;
			ri_q        <= '0;
			last_q      <= '0;
			pass_q      <= 5'd0;
		end else begin
			state_q <= state_d;
			fwd_s1  <= rd_en && wr_en && (rd_addr == wr_addr);
			pend_s1 <= (state_q == BK_TICK) && issuing_q;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			if (start_tick) begin
				issuing_q <= 1'b1;
				moved_q   <= 1'b0;
				ri_q      <= '0;
				last_q    <= last_d;
				pass_q    <= head.head.tick_count - 5'd1;
			end else if (state_q == BK_TICK) begin
				if (pend_s1 && step_moved) begin
					moved_q <= 1'b1;
				end
				if (issuing_q) begin
					if (ri_q == last_q) begin
						ri_q <= '0;
						if (pass_q == 5'd0) begin
							issuing_q <= 1'b0;
						end else begin
							pass_q <= pass_q - 5'd1;
						end
					end else begin
						ri_q <= ri_q + AW'(1);
					end
				end
			end
		end
	end

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> (!res_valid_q || !res_stall))
		else $error("result loaded over a waiting result");

	a_pend_in_tick: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == BK_TICK && addr_s1 <= last_q))
		else $error("melt write outside a tick walk");

	a_rise_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(res_load))
		else $error("result valid without a completed command");

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (state_q == BK_IDLE && head.valid))
		else $error("queue popped while busy or empty");

endmodule

[hdl/column_melt_wipe_engine_core.sv]
`timescale 1ns / 1ps
// column_melt_wipe_engine_core: top level of the column melt wipe engine
// depends on cmwe_pkg, cmwe_front, cmwe_queue, cmwe_back and cmwe_ram
//
// usage
// item channel: item_valid/item_stall with an item_t payload; a transaction is
//   a seed (one column offset), a tick (melt every column tick_count times) or
//   a pixel query. every item gives exactly one res_t transaction, in order.
// result channel: res_valid/res_stall; seeds and no-ops return all zeros,
//   ticks return done_res, queries return from_end_screen and source_row.
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; write only
//   while the block is idle. cfg_ready is always high.
// flow: items pass a two-entry queue, then the back end. seed of column 0,
//   no-ops, out-of-range items and empty ticks finish in the back end's idle
//   state; other seeds and queries add one offset ram read; a tick walks
//   min(columns_in_use, MAX_COLUMNS) columns tick_count times, one column per
//   cycle through the single read port of the offset ram.
// stall: when res_stall holds, the result register holds, the back end waits
//   and the queue fills; item_stall rises once two items are waiting.
// reset: registers return to 160 columns, 200 rows, standard mode; the
//   offset ram is not cleared and offsets must be seeded before use.
module column_melt_wipe_engine_core import cmwe_pkg::*; #(
	parameter int MAX_COLUMNS = 512,
	parameter int ROW_BITS    = 10
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  item_t      item_data,
	output logic       res_valid,
	input  logic       res_stall,
	output res_t       res_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [9:0] cfg_data
);

	logic [9:0] columns_in_use_q;
	logic [9:0] screen_rows_q;
	logic       fixed_step_mode_q;

	logic      queue_full;
	logic      push;
	cmd_t      push_cmd;
	logic      pop;
	cmd_head_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_in_use_q  <= COLUMNS_RESET;
			screen_rows_q     <= ROWS_RESET;
			fixed_step_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_COLUMNS_IN_USE:  columns_in_use_q  <= cfg_data;
				CFG_SCREEN_ROWS:     screen_rows_q     <= cfg_data;
				CFG_FIXED_STEP_MODE: fixed_step_mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	cmwe_front #(
		.MAX_COLUMNS (MAX_COLUMNS)
	) u_front (
		.item_valid (item_valid),
		.item_data  (item_data),
		.item_stall (item_stall),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	cmwe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.head     (head)
	);

	cmwe_back #(
		.MAX_COLUMNS (MAX_COLUMNS),
		.ROW_BITS    (ROW_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.pop             (pop),
		.columns_in_use  (columns_in_use_q),
		.screen_rows     (screen_rows_q),
		.fixed_step_mode (fixed_step_mode_q),
		.res_valid       (res_valid),
		.res_data        (res_data),
		.res_stall       (res_stall)
	);

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking testbench for column_melt_wipe_engine_core
// depends on cmwe_pkg and the engine rtl; predicts every result in order and compares it

module tb;
	import cmwe_pkg::*;

	localparam int MAX_COLS    = 512;
	localparam int ROW_BITS    = 10;
	localparam int OFS_HI      = (1 << (ROW_BITS + 1)) - 1;
	localparam int OFS_LO      = -OFS_HI - 1;
	localparam int STUCK_LIMIT = 40000;

	localparam int IDLE_NONE     = 0;
	localparam int IDLE_SENDER   = 1;
	localparam int IDLE_RECEIVER = 2;
	localparam int IDLE_BOTH     = 3;

	logic       clk        = 1'b0;
	logic       arst_n     = 1'b0;
	logic       item_valid = 1'b0;
	logic       item_stall;
	item_t      item_data  = '0;
	logic       res_valid;
	logic       res_stall  = 1'b0;
	res_t       res_data;
	logic       cfg_valid  = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index  = CFG_COLUMNS_IN_USE;
	logic [9:0] cfg_data   = '0;

	column_melt_wipe_engine_core #(
		.MAX_COLUMNS(MAX_COLS),
		.ROW_BITS   (ROW_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item_data (item_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor copy of the engine state
	logic signed [ROW_BITS+1:0] melt_ofs [MAX_COLS];
	logic [9:0] m_cols;
	logic [9:0] m_rows;
	logic       m_fixed;

	item_t items_to_send [$];
	res_t  due_results [$];
	int    outstanding   = 0;
	logic  item_taken    = 1'b0;
	int    send_gap_pct  = 0;
	int    stall_pct     = 0;
	int    err_cnt       = 0;
	int    stuck_cycles  = 0;
	int    gen_top       = 0;
	int    g_rows        = 200;

	function automatic logic signed [ROW_BITS+1:0] clamp_ofs(int v);
		if (v > OFS_HI)
			return OFS_HI[ROW_BITS+1:0];
		if (v < OFS_LO)
			return OFS_LO[ROW_BITS+1:0];
		return v[ROW_BITS+1:0];
	endfunction

	function automatic res_t melt_predict(item_t it);
		res_t r;
		int   v, y, n, h, dy;
		bit   moved;
		r = '0;
		case (it.action)
		ACT_SEED: begin
			if (int'(it.column) < MAX_COLS) begin
				if (it.column == 0) begin
					v = -int'(it.random_value);
				end else begin
					v = int'(melt_ofs[it.column - 1]) + int'(it.random_value % 3) - 1;
					if (v > 0)
						v = 0;
					else if (v == -16)
						v = -15;
				end
				melt_ofs[it.column] = clamp_ofs(v);
			end
		end
		ACT_TICK: begin
			n = (int'(m_cols) < MAX_COLS) ? int'(m_cols) : MAX_COLS;
			h = int'(m_rows);
			moved = 1'b0;
			for (int t = 0; t < int'(it.tick_count); t++) begin
				for (int i = 0; i < n; i++) begin
					y = int'(melt_ofs[i]);
					if (y < 0) begin
						y++;
						moved = 1'b1;
					end else if (y < h) begin
						if (m_fixed) begin
							y += 13;
						end else begin
							dy = (y < 16) ? y + 1 : 8;
							if (y + dy >= h)
								dy = h - y;
							y += dy;
						end
						moved = 1'b1;
					end
					melt_ofs[i] = clamp_ofs(y);
				end
			end
			r.done_res = !moved;
		end
		ACT_QUERY: begin
			y = (int'(it.column) < MAX_COLS) ? int'(melt_ofs[it.column]) : 0;
			if (y < 0)
				y = 0;
			if (m_fixed) begin
				r.source_row = it.row;
			end else if (int'(it.row) < y) begin
				r.from_end_screen = 1'b1;
				r.source_row = it.row;
			end else begin
				r.source_row = 10'(int'(it.row) - y);
			end
		end
		default: ;
		endcase
		return r;
	endfunction

	task automatic log_error(string msg);
		if (err_cnt < 10)
			$display("%s", msg);
		err_cnt++;
	endtask

	// driver: holds a stalled transaction, otherwise sends or idles
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_taken) begin
			if (items_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				item_data  <= items_to_send.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk)
		res_stall <= arst_n && ($urandom_range(99) < stall_pct);

	// monitor: predict on item acceptance, check on result acceptance
	always @(posedge clk) begin
		res_t want;
		if (!arst_n) begin
			m_cols = COLUMNS_RESET;
			m_rows = ROWS_RESET;
			m_fixed = 1'b0;
			item_taken <= 1'b0;
			outstanding <= 0;
		end else begin
			item_taken <= item_valid && !item_stall;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				CFG_COLUMNS_IN_USE:  m_cols = cfg_data;
				CFG_SCREEN_ROWS:     m_rows = cfg_data;
				CFG_FIXED_STEP_MODE: m_fixed = cfg_data[0];
				default: ;
				endcase
			end
			if (item_valid && !item_stall)
				due_results.push_back(melt_predict(item_data));
			if (res_valid && !res_stall) begin
				if (due_results.size() == 0) begin
					log_error($sformatf("unexpected result: done=%0d end=%0d row=%0d",
						res_data.done_res, res_data.from_end_screen, res_data.source_row));
				end else begin
					want = due_results.pop_front();
					if (want.done_res !== res_data.done_res ||
					    want.from_end_screen !== res_data.from_end_screen ||
					    want.source_row !== res_data.source_row)
						log_error($sformatf(
							"mismatch: expected done=%0d end=%0d row=%0d, got done=%0d end=%0d row=%0d",
							want.done_res, want.from_end_screen, want.source_row,
							res_data.done_res, res_data.from_end_screen, res_data.source_row));
				end
			end
			outstanding <= due_results.size();
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && !item_stall) || (res_valid && !res_stall) ||
		    (!item_valid && outstanding == 0)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic set_idling(int mode);
		case (mode)
		IDLE_NONE: begin
			send_gap_pct = 0;
			stall_pct = 0;
		end
		IDLE_SENDER: begin
			send_gap_pct = 73;
			stall_pct = 0;
		end
		IDLE_RECEIVER: begin
			send_gap_pct = 0;
			stall_pct = 73;
		end
		default: begin
			send_gap_pct = 19;
			stall_pct = 19;
		end
		endcase
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (items_to_send.size() != 0 || item_valid || outstanding != 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [9:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic configure(int cols, int rows, int mode);
		wait_idle();
		write_reg(CFG_COLUMNS_IN_USE, 10'(cols));
		write_reg(CFG_SCREEN_ROWS, 10'(rows));
		write_reg(CFG_FIXED_STEP_MODE, 10'(mode));
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
		g_rows = rows;
	endtask

	// seeds only go to column 0 or right after a written column
	task automatic queue_item(item_t it);
		if (it.action == ACT_SEED && int'(it.column) == gen_top)
			gen_top++;
		items_to_send.push_back(it);
	endtask

	function automatic item_t mk_item(logic [1:0] act, int col, int row, int rnd, int ticks);
		item_t it;
		it.action       = act;
		it.column       = 9'(col);
		it.row          = 10'(row);
		it.random_value = 4'(rnd);
		it.tick_count   = 5'(ticks);
		return it;
	endfunction

	function automatic item_t rand_item();
		return mk_item(ACT_NOP, $urandom_range(0, 511), $urandom_range(0, 1022),
			$urandom_range(0, 15), $urandom_range(0, 31));
	endfunction

	task automatic seed_sweep(int from, int upto);
		item_t it;
		for (int c = from; c < upto; c++) begin
			it = rand_item();
			it.action = ACT_SEED;
			it.column = 9'(c);
			queue_item(it);
		end
	endtask

	task automatic gen_mix(int count, int n);
		item_t it;
		int    pick;
		int    hi;
		for (int k = 0; k < count; k++) begin
			it = rand_item();
			pick = $urandom_range(99);
			if (pick < 20) begin
				if (n <= 16 && $urandom_range(7) == 0) begin
					seed_sweep(0, n);
					continue;
				end
				it.action = ACT_SEED;
				it.column = 9'($urandom_range(0, gen_top < MAX_COLS - 1 ? gen_top : MAX_COLS - 1));
			end else if (pick < 36) begin
				it.action = ACT_TICK;
				if ($urandom_range(29) == 0)
					it.tick_count = '0;
				else if (n > 64)
					it.tick_count = 5'($urandom_range(1, 3));
				else
					it.tick_count = 5'($urandom_range(1, 16));
			end else if (pick < 95) begin
				it.action = ACT_QUERY;
				it.column = 9'($urandom_range(0, gen_top - 1));
				if ($urandom_range(1) == 0) begin
					hi = (g_rows + 16 < 1022) ? g_rows + 16 : 1022;
					it.row = 10'($urandom_range(0, hi));
				end
			end
			queue_item(it);
		end
	endtask

	task automatic run_phase(int cols, int rows, int mode, int idle, int mix);
		int n;
		configure(cols, rows, mode);
		set_idling(idle);
		n = (cols < MAX_COLS) ? cols : MAX_COLS;
		seed_sweep((n <= 64) ? 0 : gen_top, n);
		gen_mix(mix / 2, n);
		// sender holds off until every result is back
		wait_idle();
		gen_mix(mix - mix / 2, n);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_idling(IDLE_NONE);

		// reset configuration: no-ops, seeds and queries
		queue_item(mk_item(ACT_NOP, 511, 1022, 15, 31));
		queue_item(mk_item(ACT_NOP, 0, 0, 0, 0));
		queue_item(mk_item(ACT_SEED, 0, 0, 15, 0));
		queue_item(mk_item(ACT_SEED, 1, 0, 0, 0));
		queue_item(mk_item(ACT_SEED, 2, 0, 2, 0));
		queue_item(mk_item(ACT_SEED, 3, 0, 14, 0));
		queue_item(mk_item(ACT_QUERY, 0, 0, 0, 0));
		queue_item(mk_item(ACT_QUERY, 3, 1022, 0, 0));
		queue_item(mk_item(ACT_SEED, 0, 0, 0, 0));
		queue_item(mk_item(ACT_SEED, 1, 0, 2, 0));
		queue_item(mk_item(ACT_QUERY, 1, 5, 0, 0));

		// two columns, one row: zero ticks, then melt to the bottom
		configure(2, 1, 0);
		queue_item(mk_item(ACT_TICK, 0, 0, 0, 0));
		queue_item(mk_item(ACT_TICK, 0, 0, 0, 1));
		queue_item(mk_item(ACT_TICK, 0, 0, 0, 16));
		queue_item(mk_item(ACT_QUERY, 0, 0, 0, 0));

		configure(2, 1023, 1);
		queue_item(mk_item(ACT_TICK, 0, 0, 0, 16));
		queue_item(mk_item(ACT_QUERY, 1, 1022, 0, 0));
		queue_item(mk_item(ACT_QUERY, 0, 0, 0, 0));

		configure(2, 1023, 0);
		queue_item(mk_item(ACT_QUERY, 1, 100, 0, 0));
		queue_item(mk_item(ACT_QUERY, 1, 1022, 0, 0));
		queue_item(mk_item(ACT_QUERY, 1, 208, 0, 0));
		queue_item(mk_item(ACT_QUERY, 1, 209, 0, 0));
		queue_item(mk_item(ACT_TICK, 0, 0, 0, 16));

		run_phase(160, 200, 0, IDLE_NONE, 14);
		run_phase(1, 1, 0, IDLE_SENDER, 14);
		run_phase(37, 1023, 1, IDLE_RECEIVER, 14);
		run_phase(512, 1023, 0, IDLE_BOTH, 14);
		run_phase(1023, $urandom_range(1, 1023), 0, IDLE_NONE, 14);
		run_phase(300, $urandom_range(1, 1023), 1, IDLE_SENDER, 14);
		run_phase(8, $urandom_range(1, 1023), 0, IDLE_RECEIVER, 14);
		run_phase(64, 1, 1, IDLE_BOTH, 14);
		run_phase(2, 1023, 0, IDLE_NONE, 14);
		run_phase($urandom_range(1, 100), $urandom_range(1, 1023), $urandom_range(0, 1),
			IDLE_BOTH, 14);

		wait_idle();
		repeat (20) @(posedge clk);
		if (due_results.size() != 0)
			log_error($sformatf("%0d results never arrived", due_results.size()));
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
